FILE: hdl/two_level_process_grid_resolver_macros.svh
// assertion macros for the grid resolver
`ifndef TWO_LEVEL_PROCESS_GRID_RESOLVER_MACROS_SVH
`define TWO_LEVEL_PROCESS_GRID_RESOLVER_MACROS_SVH
`define TLG_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define TLG_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

FILE: hdl/tlg_pkg.sv
// types and constants for the grid resolver
package tlg_pkg;
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_ZERO      = 3'd1;
    localparam logic [2:0] ST_OUTER_BIG = 3'd2;
    localparam logic [2:0] ST_PRODUCT   = 3'd3;
    localparam logic [2:0] ST_DIV_OUTER = 3'd4;
    localparam logic [2:0] ST_DIV_INNER = 3'd5;
    localparam logic [2:0] ST_TOO_MANY  = 3'd6;

    typedef enum logic [3:0] {
        S_IDLE, S_CHECK, S_MUL, S_DIV_START, S_DIV_WAIT, S_DIV_DONE,
        S_GCD_START, S_GCD_WAIT, S_SQ_START, S_SQ_WAIT, S_SQ_SQRT, S_SQ_SQRTW,
        S_FINISH, S_OUT
    } t_state;

    typedef enum logic [2:0] {
        K_NONE, K_OUTER, K_INNER, K_GCD, K_TRY, K_FINAL
    } t_div_kind;

    typedef struct packed {
        logic load;
        logic div_start;
        logic sqrt_start;
        logic [2:0] sel;
        logic mul;
        logic d_init;
        logic d_next;
        logic take_best;
        logic gcd_step;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic div_busy;
        logic sqrt_busy;
        logic rem_zero;
        logic b_zero;
        logic d_over;
        logic is_square;
        logic tot_zero;
        logic items_zero;
        logic ro_zero;
        logic ri_zero;
        logic ro_gt_items;
        logic items_ge_tot;
        logic fav;
        logic quot_gt_items;
        logic prod_eq;
    } t_stat;

    localparam logic [2:0] SEL_TOT_RO   = 3'd0;
    localparam logic [2:0] SEL_TOT_RI   = 3'd1;
    localparam logic [2:0] SEL_GCD      = 3'd2;
    localparam logic [2:0] SEL_G_D      = 3'd3;
    localparam logic [2:0] SEL_TOT_E    = 3'd4;
    localparam logic [2:0] SEL_TOT_O    = 3'd5;
    localparam logic [2:0] SEL_TOT_D    = 3'd6;
endpackage

FILE: hdl/tlg_divider.sv
// restoring divider, one quotient bit per cycle
module tlg_divider import tlg_pkg::*; #(
    parameter int W = 24
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic [W-1:0] i_num,
    input  logic [W-1:0] i_den,
    output logic         o_busy,
    output logic [W-1:0] o_quot,
    output logic [W-1:0] o_rem
);
    localparam int CW = $clog2(W + 1);
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic [W-1:0]  r_q, r_r, r_d;
    logic [W:0]    w_sh;
    logic [W:0]    w_sub;
    assign w_sh  = {r_r, r_q[W-1]};
    assign w_sub = w_sh - {1'b0, r_d};
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CW'(W);
            r_q    <= i_num;
            r_r    <= '0;
            r_d    <= i_den;
        end else if (r_busy) begin
            if (!w_sub[W]) begin
                r_r <= w_sub[W-1:0];
                r_q <= {r_q[W-2:0], 1'b1};
            end else begin
                r_r <= w_sh[W-1:0];
                r_q <= {r_q[W-2:0], 1'b0};
            end
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == CW'(1)) r_busy <= 1'b0;
        end
    end
    assign o_busy = r_busy;
    assign o_quot = r_q;
    assign o_rem  = r_r;
endmodule

FILE: hdl/tlg_sqrt.sv
// integer square root, one result bit per cycle
module tlg_sqrt import tlg_pkg::*; #(
    parameter int W = 24
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic [W-1:0] i_val,
    output logic         o_busy,
    output logic         o_square
);
    localparam int H  = (W + 1) / 2;
    localparam int EW = 2 * H;
    localparam int CW = $clog2(H + 1);
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic [EW-1:0] r_v, r_res, r_bit;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CW'(H);
            r_v    <= EW'(i_val);
            r_res  <= '0;
            r_bit  <= EW'(1) << (EW - 2);
        end else if (r_busy) begin
            if (r_v >= r_res + r_bit) begin
                r_v   <= r_v - (r_res + r_bit);
                r_res <= (r_res >> 1) + r_bit;
            end else begin
                r_res <= r_res >> 1;
            end
            r_bit <= r_bit >> 2;
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == CW'(1)) r_busy <= 1'b0;
        end
    end
    assign o_busy   = r_busy;
    assign o_square = (r_v == '0);
endmodule

FILE: hdl/tlg_datapath.sv
// operand registers, shared divider and square root, result assembly
module tlg_datapath import tlg_pkg::*; #(
    parameter int W = 24
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  t_cmd         i_cmd,
    input  logic [2:0]   i_status,
    input  logic [W-1:0] i_req_outer,
    input  logic [W-1:0] i_req_inner,
    input  logic [W-1:0] i_total_workers,
    input  logic [W-1:0] i_outer_items,
    input  logic         i_favor_square,
    output t_stat        o_stat,
    output logic [W-1:0] o_outer_count,
    output logic [W-1:0] o_inner_count
);
    logic [W-1:0] r_ro, r_ri, r_tot, r_items, r_a, r_b, r_d, r_e, r_best;
    logic         r_fav, r_prod_eq;
    logic [W-1:0] r_oc, r_ic;
    logic [W-1:0] w_num, w_den, w_q, w_r, w_o;
    logic [2*W-1:0] w_dd;
    logic         w_dbusy, w_sbusy, w_sq;

    assign w_o  = (r_best != '0) ? r_best : r_a;
    assign w_dd = r_d * r_d;

    always_comb begin
        unique case (i_cmd.sel)
            SEL_TOT_RO: begin w_num = r_tot; w_den = r_ro;  end
            SEL_TOT_RI: begin w_num = r_tot; w_den = r_ri;  end
            SEL_GCD:    begin w_num = r_a;   w_den = r_b;   end
            SEL_G_D:    begin w_num = r_a;   w_den = r_d;   end
            SEL_TOT_E:  begin w_num = r_tot; w_den = r_e;   end
            SEL_TOT_D:  begin w_num = r_tot; w_den = r_d;   end
            default:    begin w_num = r_tot; w_den = w_o;   end
        endcase
    end

    tlg_divider #(.W(W)) u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_cmd.div_start),
        .i_num(w_num), .i_den(w_den), .o_busy(w_dbusy), .o_quot(w_q), .o_rem(w_r)
    );
    tlg_sqrt #(.W(W)) u_sqrt (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_cmd.sqrt_start),
        .i_val(w_q), .o_busy(w_sbusy), .o_square(w_sq)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_ro    <= i_req_outer;
            r_ri    <= i_req_inner;
            r_tot   <= i_total_workers;
            r_items <= i_outer_items;
            r_fav   <= i_favor_square;
            r_a     <= i_outer_items;
            r_b     <= i_total_workers;
            r_best  <= '0;
        end
        if (i_cmd.mul) r_prod_eq <= ((2*W)'(r_ro) * (2*W)'(r_ri)) == (2*W)'(r_tot);
        if (i_cmd.gcd_step) begin
            r_a <= r_b;
            r_b <= w_r;
        end
        if (i_cmd.d_init) r_d <= W'(1);
        if (i_cmd.d_next) r_d <= r_d + 1'b1;
        // quotient of g / d kept for the partner divisor
        if (i_cmd.sel == SEL_G_D && !w_dbusy && !i_cmd.div_start) r_e <= w_q;
        if (i_cmd.take_best) begin
            if (i_cmd.sel == SEL_TOT_E) begin
                if (r_e > r_best) r_best <= r_e;
            end else if (r_d > r_best) begin
                r_best <= r_d;
            end
        end
        if (i_cmd.finish) begin
            if (i_status != ST_OK) begin
                r_oc <= '0; r_ic <= '0;
            end else if (r_ro != '0 && r_ri != '0) begin
                r_oc <= r_ro; r_ic <= r_ri;
            end else if (r_ro != '0) begin
                r_oc <= r_ro; r_ic <= w_q;
            end else if (r_ri != '0) begin
                r_oc <= w_q; r_ic <= r_ri;
            end else if (r_items >= r_tot) begin
                r_oc <= r_tot; r_ic <= W'(1);
            end else begin
                r_oc <= w_o; r_ic <= w_q;
            end
        end
    end

    assign o_stat.div_busy      = w_dbusy;
    assign o_stat.sqrt_busy     = w_sbusy;
    assign o_stat.rem_zero      = (w_r == '0);
    assign o_stat.b_zero        = (r_b == '0);
    assign o_stat.d_over        = w_dd > (2*W)'(r_a);
    assign o_stat.is_square     = w_sq;
    assign o_stat.tot_zero      = (r_tot == '0);
    assign o_stat.items_zero    = (r_items == '0);
    assign o_stat.ro_zero       = (r_ro == '0);
    assign o_stat.ri_zero       = (r_ri == '0);
    assign o_stat.ro_gt_items   = (r_ro > r_items);
    assign o_stat.items_ge_tot  = (r_items >= r_tot);
    assign o_stat.fav           = r_fav;
    assign o_stat.quot_gt_items = (w_q > r_items);
    assign o_stat.prod_eq       = r_prod_eq;
    assign o_outer_count = r_oc;
    assign o_inner_count = r_ic;
endmodule

FILE: hdl/tlg_controller.sv
// sequencer for the checks, gcd and square divisor search
module tlg_controller import tlg_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic       i_out_stall,
    input  t_stat      i_stat,
    output logic       o_stall,
    output logic       o_valid,
    output t_cmd       o_cmd,
    output logic [2:0] o_status
);
    `include "two_level_process_grid_resolver_macros.svh"
    t_state    r_state, n_state;
    t_div_kind r_kind, n_kind;
    logic [2:0] r_st, n_st;
    logic      r_phase, n_phase;
    logic      w_done;

    assign w_done = !i_stat.div_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_kind  <= K_NONE;
            r_st    <= ST_OK;
            r_phase <= 1'b0;
        end else begin
            r_state <= n_state;
            r_kind  <= n_kind;
            r_st    <= n_st;
            r_phase <= n_phase;
        end
    end

    always_comb begin
        n_state = r_state;
        n_kind  = r_kind;
        n_st    = r_st;
        n_phase = r_phase;
        o_cmd   = '0;
        o_cmd.sel = SEL_TOT_RO;
        o_stall = (r_state != S_IDLE);
        o_valid = (r_state == S_OUT);
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_st = ST_OK;
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                o_cmd.mul = 1'b1;
                priority if (i_stat.tot_zero || i_stat.items_zero) begin
                    n_st = ST_ZERO; n_state = S_FINISH;
                end else if (!i_stat.ro_zero && i_stat.ro_gt_items) begin
                    n_st = ST_OUTER_BIG; n_state = S_FINISH;
                end else if (!i_stat.ro_zero && !i_stat.ri_zero) begin
                    n_state = S_MUL;
                end else if (!i_stat.ro_zero) begin
                    n_kind = K_OUTER; n_state = S_DIV_START;
                end else if (!i_stat.ri_zero) begin
                    n_kind = K_INNER; n_state = S_DIV_START;
                end else if (i_stat.items_ge_tot) begin
                    n_state = S_FINISH;
                end else begin
                    n_kind = K_GCD; n_state = S_GCD_START;
                end
            end
            S_MUL: begin
                if (!i_stat.prod_eq) n_st = ST_PRODUCT;
                n_state = S_FINISH;
            end
            S_DIV_START: begin
                o_cmd.div_start = 1'b1;
                unique case (r_kind)
                    K_OUTER: o_cmd.sel = SEL_TOT_RO;
                    K_INNER: o_cmd.sel = SEL_TOT_RI;
                    default: o_cmd.sel = SEL_TOT_O;
                endcase
                n_state = S_DIV_WAIT;
            end
            S_DIV_WAIT: begin
                if (w_done) n_state = S_DIV_DONE;
            end
            S_DIV_DONE: begin
                priority if (r_kind == K_OUTER && !i_stat.rem_zero) n_st = ST_DIV_OUTER;
                else if (r_kind == K_INNER && !i_stat.rem_zero) n_st = ST_DIV_INNER;
                else if (r_kind == K_INNER && i_stat.quot_gt_items) n_st = ST_TOO_MANY;
                else n_st = ST_OK;
                o_cmd.finish = 1'b1;
                n_state = S_OUT;
            end
            S_GCD_START: begin
                o_cmd.sel = SEL_GCD;
                if (i_stat.b_zero) begin
                    o_cmd.d_init = 1'b1;
                    n_state = i_stat.fav ? S_SQ_START : S_DIV_START;
                    n_kind = i_stat.fav ? K_TRY : K_FINAL;
                    n_phase = 1'b0;
                end else begin
                    o_cmd.div_start = 1'b1;
                    n_state = S_GCD_WAIT;
                end
            end
            S_GCD_WAIT: begin
                o_cmd.sel = SEL_GCD;
                if (w_done) begin
                    o_cmd.gcd_step = 1'b1;
                    n_state = S_GCD_START;
                end
            end
            S_SQ_START: begin
                if (i_stat.d_over) begin
                    n_kind = K_FINAL; n_state = S_DIV_START;
                end else begin
                    o_cmd.sel = SEL_G_D;
                    o_cmd.div_start = 1'b1;
                    n_phase = 1'b0;
                    n_state = S_SQ_WAIT;
                end
            end
            S_SQ_WAIT: begin
                o_cmd.sel = r_phase ? SEL_TOT_D : SEL_G_D;
                if (w_done) begin
                    if (!r_phase && !i_stat.rem_zero) begin
                        o_cmd.d_next = 1'b1;
                        n_state = S_SQ_START;
                    end else begin
                        n_state = S_SQ_SQRT;
                    end
                end
            end
            S_SQ_SQRT: begin
                // phase 0: e captured, divide tot by e; then tot by d
                o_cmd.sel = r_phase ? SEL_TOT_D : SEL_TOT_E;
                o_cmd.div_start = 1'b1;
                n_state = S_SQ_SQRTW;
            end
            S_SQ_SQRTW: begin
                o_cmd.sel = r_phase ? SEL_TOT_D : SEL_TOT_E;
                if (w_done && !i_stat.sqrt_busy) begin
                    if (!r_kind[0]) begin
                        o_cmd.sqrt_start = 1'b1;
                        n_kind = K_FINAL;
                    end else begin
                        o_cmd.take_best = i_stat.is_square;
                        n_kind = K_TRY;
                        if (r_phase) begin
                            o_cmd.d_next = 1'b1;
                            n_state = S_SQ_START;
                        end else begin
                            n_phase = 1'b1;
                            n_state = S_SQ_SQRT;
                        end
                    end
                end
            end
            S_FINISH: begin
                o_cmd.finish = 1'b1;
                n_state = S_OUT;
            end
            S_OUT: begin
                if (!i_out_stall) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end
    assign o_status = (r_state == S_DIV_DONE) ? n_st : r_st;

    `TLG_ASSERT_IMPL(a_out_only_in_out, i_clk, i_rst_n, o_valid, r_state == S_OUT)
    `TLG_ASSERT_NEXT(a_load_leaves_idle, i_clk, i_rst_n, r_state == S_IDLE && i_valid,
        r_state == S_CHECK)
    `TLG_ASSERT_NEXT(a_out_holds, i_clk, i_rst_n, o_valid && i_out_stall, o_valid)
endmodule

FILE: hdl/two_level_process_grid_resolver.sv
// Splits a worker count into outer groups times inner workers, one request at a
// time. The time to a result is data dependent: zero and outer-size errors and
// requests with both sizes given finish without the divider; a request with one
// size given takes one pass of the W-step shared divider; automatic requests
// add one divider pass per Euclid step of the gcd and, with the square
// preference, up to three divider passes and two square root passes per
// candidate divisor up to sqrt(g).
module two_level_process_grid_resolver import tlg_pkg::*; #(
    parameter int COUNT_WIDTH = 24
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_stall,
    input  logic [COUNT_WIDTH-1:0] i_req_outer,
    input  logic [COUNT_WIDTH-1:0] i_req_inner,
    input  logic [COUNT_WIDTH-1:0] i_total_workers,
    input  logic [COUNT_WIDTH-1:0] i_outer_items,
    input  logic                   i_favor_square,
    output logic                   o_valid,
    input  logic                   i_stall,
    output logic [COUNT_WIDTH-1:0] o_outer_count,
    output logic [COUNT_WIDTH-1:0] o_inner_count,
    output logic [2:0]             o_status
);
    t_cmd       w_cmd;
    t_stat      w_stat;
    logic [2:0] w_st;
    logic [2:0] r_status;

    tlg_controller u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .i_out_stall(i_stall),
        .i_stat(w_stat), .o_stall(o_stall), .o_valid(o_valid), .o_cmd(w_cmd),
        .o_status(w_st)
    );
    tlg_datapath #(.W(COUNT_WIDTH)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(w_cmd), .i_status(w_st),
        .i_req_outer(i_req_outer), .i_req_inner(i_req_inner),
        .i_total_workers(i_total_workers), .i_outer_items(i_outer_items),
        .i_favor_square(i_favor_square), .o_stat(w_stat),
        .o_outer_count(o_outer_count), .o_inner_count(o_inner_count)
    );
    always_ff @(posedge i_clk) begin
        if (w_cmd.finish) r_status <= w_st;
    end
    assign o_status = r_status;
endmodule

FILE: tb/sv/tb.sv
// testbench for the two-level worker grid resolver
`timescale 1ns / 1ps
module tb;
    import tlg_pkg::*;

    localparam int W = 24;
    localparam int IDLE_LIMIT = 2000000;

    typedef struct packed {
        logic [W-1:0] outer_count;
        logic [W-1:0] inner_count;
        logic [2:0]   status;
    } t_shape;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         i_valid = 1'b0;
    logic         o_stall;
    logic [W-1:0] i_req_outer = '0;
    logic [W-1:0] i_req_inner = '0;
    logic [W-1:0] i_total_workers = '0;
    logic [W-1:0] i_outer_items = '0;
    logic         i_favor_square = 1'b0;
    logic         o_valid;
    logic         i_stall = 1'b0;
    logic [W-1:0] o_outer_count;
    logic [W-1:0] o_inner_count;
    logic [2:0]   o_status;

    t_shape shapes_due[$];
    int     mismatches = 0;
    int     requests_sent = 0;
    int     shapes_seen = 0;
    int     status_seen[8];
    int     idle_cycles = 0;
    bit     gaps_on = 1'b1;

    two_level_process_grid_resolver #(.COUNT_WIDTH(W)) dut (.*);

    always #6 i_clk = ~i_clk;

    function automatic bit is_square(longint unsigned n);
        longint unsigned lo, hi, mid;
        lo = 0;
        hi = 1 << 25;
        while (lo < hi) begin
            mid = (lo + hi + 1) >> 1;
            if (mid * mid <= n) lo = mid;
            else hi = mid - 1;
        end
        return lo * lo == n;
    endfunction

    function automatic t_shape resolve_shape(logic [W-1:0] ro, logic [W-1:0] ri,
                                             logic [W-1:0] tot, logic [W-1:0] items,
                                             logic fav);
        t_shape s;
        longint unsigned a, b, t, g, best, d, e;
        s = '{default: '0};
        s.status = ST_OK;
        if (tot == 0 || items == 0) s.status = ST_ZERO;
        else if (ro != 0 && ro > items) s.status = ST_OUTER_BIG;
        else if (ro != 0 && ri != 0) begin
            if (longint'(ro) * longint'(ri) != longint'(tot)) s.status = ST_PRODUCT;
            else begin
                s.outer_count = ro;
                s.inner_count = ri;
            end
        end else if (ro != 0) begin
            if (tot % ro != 0) s.status = ST_DIV_OUTER;
            else begin
                s.outer_count = ro;
                s.inner_count = tot / ro;
            end
        end else if (ri != 0) begin
            if (tot % ri != 0) s.status = ST_DIV_INNER;
            else if (tot / ri > items) s.status = ST_TOO_MANY;
            else begin
                s.outer_count = tot / ri;
                s.inner_count = ri;
            end
        end else if (items >= tot) begin
            s.outer_count = tot;
            s.inner_count = 1;
        end else begin
            a = items;
            b = tot;
            while (b != 0) begin
                t = a % b;
                a = b;
                b = t;
            end
            g = a;
            best = 0;
            if (fav) begin
                for (d = 1; d * d <= g; d++) begin
                    if (g % d == 0) begin
                        e = g / d;
                        if (e > best && is_square(tot / e)) best = e;
                        if (d > best && is_square(tot / d)) best = d;
                    end
                end
            end
            if (best == 0) best = g;
            s.outer_count = W'(best);
            s.inner_count = W'(tot / best);
        end
        return s;
    endfunction

    function automatic int gap_length();
        int r;
        r = $urandom_range(0, 99);
        if (!gaps_on || r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic report_mismatch(string what, logic [W-1:0] got, logic [W-1:0] want);
        $display("mismatch on %s: got %0d, expected %0d", what, got, want);
        mismatches++;
    endtask

    // receiver stall pattern
    int stall_left = 0;
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
        end else if (gaps_on && $urandom_range(0, 3) == 0) begin
            i_stall <= 1'b1;
            stall_left <= gap_length();
        end else begin
            i_stall <= 1'b0;
        end
    end

    // transfer monitor, predictor and checker
    always @(posedge i_clk) begin
        t_shape want;
        bit     moved;
        moved = 1'b0;
        if (i_rst_n) begin
            if (i_valid && !o_stall) begin
                shapes_due.push_back(resolve_shape(i_req_outer, i_req_inner, i_total_workers,
                                                   i_outer_items, i_favor_square));
                moved = 1'b1;
            end
            if (o_valid && !i_stall) begin
                moved = 1'b1;
                shapes_seen++;
                if (shapes_due.size() == 0) begin
                    report_mismatch("unexpected result transfer", o_outer_count, '0);
                end else begin
                    want = shapes_due.pop_front();
                    status_seen[want.status]++;
                    if (o_outer_count !== want.outer_count)
                        report_mismatch("outer_count", o_outer_count, want.outer_count);
                    if (o_inner_count !== want.inner_count)
                        report_mismatch("inner_count", o_inner_count, want.inner_count);
                    if (o_status !== want.status)
                        report_mismatch("status", o_status, want.status);
                end
            end
            idle_cycles <= moved ? 0 : idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("watchdog expired with %0d results pending", shapes_due.size());
                $display("tb: failure");
                $finish;
            end
        end
    end

    task automatic send_request(logic [W-1:0] ro, logic [W-1:0] ri, logic [W-1:0] tot,
                                logic [W-1:0] items, logic fav);
        int gap;
        i_req_outer <= ro;
        i_req_inner <= ri;
        i_total_workers <= tot;
        i_outer_items <= items;
        i_favor_square <= fav;
        i_valid <= 1'b1;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        requests_sent++;
        @(negedge i_clk);
        gap = gap_length();
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
    endtask

    task automatic test_error_checks();
        send_request(0, 0, 0, 5, 0);
        send_request(0, 0, 7, 0, 1);
        send_request(0, 0, 0, 0, 0);
        send_request(9, 2, 18, 8, 0);
        send_request(3, 4, 13, 8, 0);
        send_request(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 1);
        send_request(5, 0, 12, 8, 0);
        send_request(0, 5, 12, 8, 0);
        send_request(0, 2, 20, 4, 0);
    endtask

    task automatic test_fixed_shapes();
        send_request(3, 4, 12, 3, 0);
        send_request(4, 0, 24, 4, 1);
        send_request(0, 6, 24, 4, 0);
        send_request(1, 24'hFFFFFF, 24'hFFFFFF, 1, 0);
        send_request(0, 1, 24'hFFFFFF, 24'hFFFFFF, 0);
        send_request(24'hFFFFFF, 0, 24'hFFFFFF, 24'hFFFFFF, 0);
    endtask

    task automatic test_auto_shapes();
        send_request(0, 0, 12, 12, 0);
        send_request(0, 0, 5, 24'hFFFFFF, 1);
        send_request(0, 0, 36, 12, 0);
        send_request(0, 0, 36, 12, 1);
        send_request(0, 0, 6, 3, 1);
        send_request(0, 0, 24'hFFFFFF, 24'hFFFFFE, 1);
        send_request(0, 0, 1 << 20, 1 << 16, 1);
        send_request(0, 0, 24'hFFFFFF, 1, 0);
    endtask

    task automatic test_random_requests(int n);
        logic [W-1:0] o, i, tot, items;
        for (int k = 0; k < n; k++) begin
            o = $urandom_range(1, 64);
            i = $urandom_range(1, 64);
            tot = o * i;
            items = $urandom_range(1, 2 * o);
            gaps_on = (k % 40) >= 10;
            case ($urandom_range(0, 7))
                0: send_request(o, i, tot, items, $urandom_range(0, 1));
                1: send_request(o, 0, tot, items, $urandom_range(0, 1));
                2: send_request(0, i, tot, items, $urandom_range(0, 1));
                3, 4: send_request(0, 0, tot, $urandom_range(1, tot), $urandom_range(0, 1));
                5: begin
                    tot = $urandom_range(1, 4095);
                    send_request(0, 0, tot, $urandom_range(1, tot + 100), 1);
                end
                6: send_request(0, 0, $urandom, $urandom, 0);
                default: send_request($urandom_range(0, 3) == 0 ? 0 : $urandom,
                                      $urandom_range(0, 3) == 0 ? 0 : $urandom,
                                      $urandom_range(0, 7) == 0 ? 0 : $urandom,
                                      $urandom_range(0, 7) == 0 ? 0 : $urandom,
                                      1'b0);
            endcase
        end
        gaps_on = 1'b1;
    endtask

    initial begin
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_error_checks();
        test_fixed_shapes();
        test_auto_shapes();
        test_random_requests(77);
        i_valid <= 1'b0;
        while (shapes_due.size() != 0) @(negedge i_clk);
        repeat (50) @(negedge i_clk);
        $display("%0d requests sent, %0d shapes checked", requests_sent, shapes_seen);
        $display("status counts ok %0d, errors %0d/%0d/%0d/%0d/%0d/%0d", status_seen[0],
                 status_seen[1], status_seen[2], status_seen[3], status_seen[4],
                 status_seen[5], status_seen[6]);
        if (mismatches == 0 && shapes_due.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule

FILE: filelist.f
+incdir+hdl
hdl/tlg_pkg.sv
hdl/tlg_divider.sv
hdl/tlg_sqrt.sv
hdl/tlg_datapath.sv
hdl/tlg_controller.sv
hdl/two_level_process_grid_resolver.sv
tb/sv/tb.sv
